[rtl/bpfa_pkg.sv]
// Package for the bitmap page frame allocator.
// Holds the request and response payload types, command and error codes, and the
// command and status structs between the controller and the datapath. No dependencies.
package bpfa_pkg;

    // Fixed field widths and limits.
    localparam int PAGE_W     = 15;
    localparam int COUNT_W    = 16;
    localparam int PAGE_LIMIT = 32768;

    // Each summary word holds one full flag per bitmap word.
    localparam int SUM_BITS  = 32;
    localparam int SUM_IDX_W = 5;

    // Shift used by the reciprocal that splits a page number into word and bit.
    localparam int DIV_SHIFT = 22;

    // Command codes.
    localparam logic [1:0] CMD_QUERY     = 2'd0;
    localparam logic [1:0] CMD_ALLOC     = 2'd1;
    localparam logic [1:0] CMD_MARK_USED = 2'd2;
    localparam logic [1:0] CMD_MARK_FREE = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_USED     = 2'd1;
    localparam logic [1:0] ERR_FREE     = 2'd2;
    localparam logic [1:0] ERR_NO_FREE  = 2'd3;

    // Request payload.
    typedef struct packed {
        logic [1:0]        cmd;
        logic [PAGE_W-1:0] page;
    } t_req;

    // Response payload.
    typedef struct packed {
        logic [PAGE_W-1:0]  page_out;
        logic               used_bit;
        logic [1:0]         error;
        logic [COUNT_W-1:0] used_count;
        logic [COUNT_W-1:0] free_count;
    } t_rsp;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic latch_req;
        logic div;
        logic split;
        logic rd_word;
        logic eval;
        logic grp;
        logic rd_sum_g;
        logic find_word;
        logic rd_sum_w;
        logic wr_sum;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic in_alloc;
        logic in_range;
        logic grp_none;
        logic need_sum;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/bpfa_ctrl.sv]
// Controller state machine of the bitmap page frame allocator.
// Sequences the clearing pass and each request through the datapath steps.
// Depends on bpfa_pkg.
module bpfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bpfa_pkg::t_dp_sts i_sts,
    output bpfa_pkg::t_dp_cmd o_cmd
);

    // One-hot state encoding.
    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_DIV   = 12'b0000_0000_0100,
        S_SPLIT = 12'b0000_0000_1000,
        S_RDW   = 12'b0000_0001_0000,
        S_EVAL  = 12'b0000_0010_0000,
        S_GRP   = 12'b0000_0100_0000,
        S_RDS   = 12'b0000_1000_0000,
        S_FWORD = 12'b0001_0000_0000,
        S_SRD   = 12'b0010_0000_0000,
        S_SWR   = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and step commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_req = 1'b1;
                    n_state = i_sts.in_alloc ? S_GRP : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_SPLIT;
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = i_sts.in_range ? S_RDW : S_DONE;
            end
            S_RDW: begin
                o_cmd.rd_word = 1'b1;
                n_state       = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.need_sum ? S_SRD : S_DONE;
            end
            S_GRP: begin
                o_cmd.grp = 1'b1;
                n_state   = i_sts.grp_none ? S_DONE : S_RDS;
            end
            S_RDS: begin
                o_cmd.rd_sum_g = 1'b1;
                n_state        = S_FWORD;
            end
            S_FWORD: begin
                o_cmd.find_word = 1'b1;
                n_state         = S_RDW;
            end
            S_SRD: begin
                o_cmd.rd_sum_w = 1'b1;
                n_state        = S_SWR;
            end
            S_SWR: begin
                o_cmd.wr_sum = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

[rtl/bpfa_dp.sv]
// Datapath of the bitmap page frame allocator.
// Holds the page bitmap memory, the word summary memory, the group flags, the used
// count and the output register. Depends on bpfa_pkg.
module bpfa_dp #(
    parameter int BITMAP_WORDS = 1024,
    parameter int WORD_BITS    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bpfa_pkg::t_req    i_req,
    input  bpfa_pkg::t_dp_cmd i_cmd,
    output bpfa_pkg::t_dp_sts o_sts,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bpfa_pkg::t_rsp    o_out_data
);

    localparam int PW = bpfa_pkg::PAGE_W;
    localparam int CW = bpfa_pkg::COUNT_W;
    localparam int SB = bpfa_pkg::SUM_BITS;
    localparam int SW = bpfa_pkg::SUM_IDX_W;

    // Managed pages and storage sizes.
    localparam int NPAGES_RAW = BITMAP_WORDS * WORD_BITS;
    localparam int NPAGES     = (NPAGES_RAW < bpfa_pkg::PAGE_LIMIT) ? NPAGES_RAW
                                                                    : bpfa_pkg::PAGE_LIMIT;
    localparam int MEM_WORDS  = (NPAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int NS         = (MEM_WORDS + SB - 1) / SB;
    localparam int WA         = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int SA         = (NS > 1) ? $clog2(NS) : 1;
    localparam int BA         = $clog2(WORD_BITS);

    // Bits past the last managed page start, and stay, marked used.
    localparam int LAST_BITS = NPAGES - (MEM_WORDS - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_INIT =
        ~({WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS));
    localparam int LAST_GRP = MEM_WORDS - (NS - 1) * SB;
    localparam logic [SB-1:0] SUM_INIT = ~({SB{1'b1}} >> (SB - LAST_GRP));

    // Reciprocal of the word width for the page split.
    localparam int RECIP   = (1 << bpfa_pkg::DIV_SHIFT) / WORD_BITS;
    localparam int RECIP_W = $clog2(RECIP + 1);

    // Memories.
    logic [WORD_BITS-1:0] r_bitmap  [MEM_WORDS];
    logic [SB-1:0]        r_summary [NS];

    // Request and working registers.
    logic [1:0]           r_cmd;
    logic [PW-1:0]        r_page;
    logic [PW-1:0]        r_pout;
    logic [PW-1:0]        r_qest;
    logic [WA-1:0]        r_word;
    logic [BA-1:0]        r_bit;
    logic [SA-1:0]        r_grp;
    logic [WORD_BITS-1:0] r_rdata;
    logic [SB-1:0]        r_sdata;
    logic                 r_before;
    logic [1:0]           r_err;
    logic                 r_sum_set;
    logic [CW-1:0]        r_used;
    logic [NS-1:0]        r_grp_full;
    logic [WA-1:0]        r_clr;
    logic                 r_out_valid;
    bpfa_pkg::t_rsp       r_out;

    // Status.
    logic clr_last;
    logic clr_in_sum;
    logic in_range;
    assign clr_last   = (r_clr == WA'(MEM_WORDS - 1));
    assign clr_in_sum = ({1'b0, r_clr} < (WA + 1)'(NS));
    assign in_range   = ({1'b0, r_page} < CW'(NPAGES));

    // Reciprocal estimate of the word index; it is exact or one low.
    logic [PW+RECIP_W-1:0] prod;
    assign prod = r_page * RECIP_W'(RECIP);

    // Correction step of the split.
    logic [PW:0]   rem;
    logic [PW-1:0] q_fix;
    logic [PW:0]   rem_fix;
    always_comb begin
        rem = {1'b0, r_page} - (PW + 1)'(r_qest * WORD_BITS);
        if (rem >= (PW + 1)'(WORD_BITS)) begin
            q_fix   = r_qest + PW'(1);
            rem_fix = rem - (PW + 1)'(WORD_BITS);
        end else begin
            q_fix   = r_qest;
            rem_fix = rem;
        end
    end

    // Lowest group that still has a word with a free page.
    logic [SA-1:0] fg_idx;
    always_comb begin
        fg_idx = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (!r_grp_full[i]) begin
                fg_idx = SA'(i);
            end
        end
    end

    // Lowest word of the group that is not full.
    logic [SW-1:0] fs_idx;
    always_comb begin
        fs_idx = '0;
        for (int i = SB - 1; i >= 0; i--) begin
            if (!r_sdata[i]) begin
                fs_idx = SW'(i);
            end
        end
    end

    // Lowest free bit of the word read.
    logic [BA-1:0] fz_bit;
    logic          fz_found;
    always_comb begin
        fz_bit   = '0;
        fz_found = 1'b0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!r_rdata[i]) begin
                fz_bit   = BA'(i);
                fz_found = 1'b1;
            end
        end
    end

    // Evaluation of the command on the word read.
    logic [BA-1:0]        tbit;
    logic                 bit_old;
    logic [WORD_BITS-1:0] bmask;
    logic                 ev_wr;
    logic                 ev_set;
    logic [1:0]           ev_err;
    logic [WORD_BITS-1:0] ev_word;
    logic                 ev_sum;
    always_comb begin
        tbit    = (r_cmd == bpfa_pkg::CMD_ALLOC) ? fz_bit : r_bit;
        bit_old = r_rdata[tbit];
        bmask   = {{(WORD_BITS - 1){1'b0}}, 1'b1} << tbit;
        ev_wr   = 1'b0;
        ev_set  = 1'b0;
        ev_err  = bpfa_pkg::ERR_OK;
        case (r_cmd)
            bpfa_pkg::CMD_QUERY: begin
                ev_err = bpfa_pkg::ERR_OK;
            end
            bpfa_pkg::CMD_ALLOC: begin
                ev_wr  = 1'b1;
                ev_set = 1'b1;
            end
            bpfa_pkg::CMD_MARK_USED: begin
                if (bit_old) begin
                    ev_err = bpfa_pkg::ERR_USED;
                end else begin
                    ev_wr  = 1'b1;
                    ev_set = 1'b1;
                end
            end
            bpfa_pkg::CMD_MARK_FREE: begin
                if (!bit_old) begin
                    ev_err = bpfa_pkg::ERR_FREE;
                end else begin
                    ev_wr = 1'b1;
                end
            end
            default: begin
                ev_err = bpfa_pkg::ERR_OK;
            end
        endcase
        ev_word = ev_set ? (r_rdata | bmask) : (r_rdata & ~bmask);
        // The summary changes when a word fills up or a full word gets a free page.
        ev_sum  = ev_wr && (ev_set ? (&ev_word) : (&r_rdata));
    end

    // Summary position of the current word.
    logic [SA-1:0] grp_w;
    logic [SW-1:0] sum_pos;
    logic [SB-1:0] smask;
    logic [SB-1:0] new_sum;
    assign grp_w   = SA'(r_word >> SW);
    assign sum_pos = SW'(r_word);
    assign smask   = {{(SB - 1){1'b0}}, 1'b1} << sum_pos;
    assign new_sum = r_sum_set ? (r_sdata | smask) : (r_sdata & ~smask);

    // Bitmap memory port.
    logic                 bm_we;
    logic [WA-1:0]        bm_wa;
    logic [WORD_BITS-1:0] bm_wd;
    always_comb begin
        bm_we = i_cmd.clr_step || (i_cmd.eval && ev_wr);
        bm_wa = i_cmd.clr_step ? r_clr : r_word;
        if (i_cmd.clr_step) begin
            bm_wd = clr_last ? LAST_INIT : '0;
        end else begin
            bm_wd = ev_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            r_bitmap[bm_wa] <= bm_wd;
        end
        if (i_cmd.rd_word) begin
            r_rdata <= r_bitmap[r_word];
        end
    end

    // Summary memory port.
    logic          sm_we;
    logic [SA-1:0] sm_wa;
    logic [SB-1:0] sm_wd;
    logic [SA-1:0] sm_ra;
    always_comb begin
        sm_we = (i_cmd.clr_step && clr_in_sum) || i_cmd.wr_sum;
        sm_wa = i_cmd.clr_step ? SA'(r_clr) : grp_w;
        if (i_cmd.clr_step) begin
            sm_wd = (SA'(r_clr) == SA'(NS - 1)) ? SUM_INIT : '0;
        end else begin
            sm_wd = new_sum;
        end
        sm_ra = i_cmd.rd_sum_g ? r_grp : grp_w;
    end

    always_ff @(posedge i_clk) begin
        if (sm_we) begin
            r_summary[sm_wa] <= sm_wd;
        end
        if (i_cmd.rd_sum_g || i_cmd.rd_sum_w) begin
            r_sdata <= r_summary[sm_ra];
        end
    end

    // Control registers: clearing counter, group flags, used count, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_grp_full  <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step && !clr_last) begin
                r_clr <= r_clr + WA'(1);
            end
            if (i_cmd.wr_sum) begin
                r_grp_full[grp_w] <= &new_sum;
            end
            if (i_cmd.eval && ev_wr) begin
                r_used <= ev_set ? (r_used + CW'(1)) : (r_used - CW'(1));
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers, one group per step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_cmd  <= i_req.cmd;
            r_page <= i_req.page;
            r_pout <= i_req.page;
        end
        if (i_cmd.div) begin
            r_qest <= PW'(prod >> bpfa_pkg::DIV_SHIFT);
        end
        if (i_cmd.split) begin
            r_word <= WA'(q_fix);
            r_bit  <= BA'(rem_fix);
            if (!in_range) begin
                // A page past the bitmap reads as used and is never changed.
                r_before <= 1'b1;
                r_err    <= (r_cmd == bpfa_pkg::CMD_QUERY) ? bpfa_pkg::ERR_OK
                                                           : bpfa_pkg::ERR_NO_FREE;
            end
        end
        if (i_cmd.grp) begin
            r_grp <= fg_idx;
            if (&r_grp_full) begin
                // Allocation with no free page left.
                r_pout   <= '0;
                r_before <= 1'b1;
                r_err    <= bpfa_pkg::ERR_NO_FREE;
            end
        end
        if (i_cmd.find_word) begin
            r_word <= WA'({r_grp, fs_idx});
        end
        if (i_cmd.eval) begin
            r_bit     <= tbit;
            r_before  <= bit_old;
            r_err     <= ev_err;
            r_sum_set <= ev_set;
            if (r_cmd == bpfa_pkg::CMD_ALLOC) begin
                r_pout <= PW'(r_word * WORD_BITS) + PW'(fz_bit);
            end
        end
        if (i_cmd.load_out) begin
            r_out.page_out   <= r_pout;
            r_out.used_bit   <= r_before;
            r_out.error      <= r_err;
            r_out.used_count <= r_used;
            r_out.free_count <= CW'(NPAGES) - r_used;
        end
    end

    // Status and outputs.
    always_comb begin
        o_sts.clr_done = clr_last;
        o_sts.in_alloc = (i_req.cmd == bpfa_pkg::CMD_ALLOC);
        o_sts.in_range = in_range;
        o_sts.grp_none = &r_grp_full;
        o_sts.need_sum = ev_sum;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The used count never passes the number of managed pages.
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(NPAGES))
        else $error("used count beyond managed pages");

    // All groups full only when every managed page is in use.
    a_full_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.grp && (&r_grp_full)) |-> (r_used == CW'(NPAGES)))
        else $error("group flags report full while pages remain free");

    // The word picked by the summary search must hold a free page.
    a_alloc_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && (r_cmd == bpfa_pkg::CMD_ALLOC)) |-> fz_found)
        else $error("summary pointed at a full word");

    // Every bitmap change moves the used count.
    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && ev_wr) |=> (r_used != $past(r_used)))
        else $error("bitmap changed without a count update");

endmodule

[rtl/bitmap_page_frame_allocator.sv]
// Bitmap page frame allocator, first fit, with one used/free bit per page frame.
// After reset the block runs a clearing pass of one bitmap word per cycle over
// min(BITMAP_WORDS, ceil(32768 / WORD_BITS)) words (1024 by default), and accepts no
// request until it is done. It then works on one request at a time. A query, mark-used
// or mark-free splits the page into word and bit, reads the bitmap word, evaluates it
// and, for a mark, writes it back; when a word turns full or leaves the full state, it
// then reads and writes the word summary. A page beyond the bitmap ends after the
// split. An allocate searches the group flags, ends there when no page is free, and
// else reads the word summary, picks its lowest word that is not full, then reads,
// evaluates and writes that word with the same summary update. The next request is
// accepted from the cycle after the result is loaded. A finished result waits in the
// output register while the next request is taken; the block only stalls when the
// next result is ready before the previous one has left.
module bitmap_page_frame_allocator #(
    parameter int BITMAP_WORDS = 1024,
    parameter int WORD_BITS    = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bpfa_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output bpfa_pkg::t_rsp o_out_data
);

    bpfa_pkg::t_dp_cmd dp_cmd;
    bpfa_pkg::t_dp_sts dp_sts;

    // Sequencer.
    bpfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // Bitmap, summary, counts and output register.
    bpfa_dp #(
        .BITMAP_WORDS (BITMAP_WORDS),
        .WORD_BITS    (WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
